>>> hw/rtl/lbsc_pkg.sv
// ----------------------------------------------------------------------------
// lbsc_pkg
// shared types, field widths and codes for the search probe-count block
// ----------------------------------------------------------------------------
package lbsc_pkg;

  // default configuration
  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned WIDTH_DEF = 16;

  // item field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned LCNT_W  = 7;
  localparam int unsigned BCNT_W  = 3;
  localparam int unsigned CMP_W   = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // compare result codes
  localparam logic [CMP_W-1:0] CMP_EQUAL       = 2'd0;
  localparam logic [CMP_W-1:0] CMP_LINEAR_MORE = 2'd1;
  localparam logic [CMP_W-1:0] CMP_BINARY_MORE = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LIN,
    S_BIN_RD,
    S_BIN_CMP,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/lbsc_in_if.sv
// ----------------------------------------------------------------------------
// lbsc_in_if
// command channel: valid/ready handshake with command and value
// ----------------------------------------------------------------------------
interface lbsc_in_if import lbsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

>>> hw/rtl/lbsc_out_if.sv
// ----------------------------------------------------------------------------
// lbsc_out_if
// result channel: valid/ready handshake with status and search results
// ----------------------------------------------------------------------------
interface lbsc_out_if import lbsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic              linear_found;
  logic [IDX_W-1:0]  linear_index;
  logic [LCNT_W-1:0] linear_count;
  logic              binary_found;
  logic [IDX_W-1:0]  binary_index;
  logic [BCNT_W-1:0] binary_count;
  logic [CMP_W-1:0]  compare_result;

  modport source (
    output valid, output status, output linear_found, output linear_index,
    output linear_count, output binary_found, output binary_index,
    output binary_count, output compare_result, input ready
  );
  modport sink (
    input valid, input status, input linear_found, input linear_index,
    input linear_count, input binary_found, input binary_index,
    input binary_count, input compare_result, output ready
  );
endinterface

>>> hw/rtl/lbsc_ram.sv
// ----------------------------------------------------------------------------
// lbsc_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module lbsc_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/linear_binary_search_compare.sv
// ----------------------------------------------------------------------------
// linear_binary_search_compare
// element store with linear and binary search, counting compares of each
// ----------------------------------------------------------------------------
// clear, append and unused commands: the sequencer goes to S_DONE, then the result
//   is registered into the output register once the output slot is free
// query: c linear compares (c <= n entries), then p binary probes
//   (p <= floor(log2 n) + 1), all reads through the single ram read port, one read a cycle
// one item at a time; next item taken the cycle after the result is registered
// rst (synchronous) empties the store and the sequencer; ram contents are kept
// ----------------------------------------------------------------------------
module linear_binary_search_compare import lbsc_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lbsc_in_if.sink    req,
  lbsc_out_if.source rsp
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // sequencer and store fill level
  state_t             state, state_next;
  logic [CNT_W-1:0]   entry_count;

  // search key and working registers
  logic [WIDTH-1:0]   key;
  logic [CNT_W-1:0]   scan_addr;      // next linear read address
  logic               pend;           // a linear read is in flight
  logic [AW-1:0]      pend_idx;       // address of that read
  logic [CNT_W-1:0]   low;            // binary window [low, hi_ex)
  logic [CNT_W-1:0]   hi_ex;
  logic [AW-1:0]      probe_idx;

  // per-item result registers
  logic               res_status;
  logic               lin_found;
  logic [AW-1:0]      lin_idx;
  logic [CNT_W-1:0]   lin_cnt;
  logic               bin_found;
  logic [AW-1:0]      bin_idx;
  logic [CNT_W-1:0]   bin_cnt;

  // output register
  logic               out_valid;
  logic               o_status;
  logic               o_lin_found;
  logic [IDX_W-1:0]   o_lin_index;
  logic [LCNT_W-1:0]  o_lin_count;
  logic               o_bin_found;
  logic [IDX_W-1:0]   o_bin_index;
  logic [BCNT_W-1:0]  o_bin_count;
  logic [CMP_W-1:0]   o_cmp;

  // ram port
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WIDTH-1:0]   ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [WIDTH-1:0]   ram_rdata;

  // decode and status
  logic               accept;
  logic               store_full;
  logic               slot_free;
  logic               lin_hit;
  logic               lin_stop;
  logic               scan_re;
  logic               bin_go;
  logic [CNT_W:0]     mid_sum;
  logic [AW-1:0]      mid;
  logic               probe_hit;
  logic [CMP_W-1:0]   cmp_code;

  lbsc_ram #(
    .WIDTH  (WIDTH),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept     = req.valid && req.ready;
  assign store_full = (entry_count == CNT_W'(DEPTH));
  assign slot_free  = !out_valid || rsp.ready;

  // linear scan: compare the read returned this cycle, stop on match or last entry
  assign lin_hit  = pend && (ram_rdata == key);
  assign lin_stop = pend && (lin_hit || (CNT_W'(pend_idx) == entry_count - CNT_W'(1)));
  assign scan_re  = (state == S_LIN) && (scan_addr < entry_count) && !lin_stop;

  // binary probe at floor midpoint of [low, hi_ex - 1]
  assign bin_go    = (low < hi_ex);
  assign mid_sum   = (CNT_W+1)'(low) + (CNT_W+1)'(hi_ex) - (CNT_W+1)'(1);
  assign mid       = AW'(mid_sum >> 1);
  assign probe_hit = (ram_rdata == key);

  always_comb begin
    if (lin_cnt > bin_cnt) begin
      cmp_code = CMP_LINEAR_MORE;
    end else if (lin_cnt < bin_cnt) begin
      cmp_code = CMP_BINARY_MORE;
    end else begin
      cmp_code = CMP_EQUAL;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.command == CMD_QUERY && entry_count != '0) begin
            state_next = S_LIN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_LIN: begin
        if (lin_stop) begin
          state_next = S_BIN_RD;
        end
      end
      S_BIN_RD: begin
        state_next = bin_go ? S_BIN_CMP : S_DONE;
      end
      S_BIN_CMP: begin
        state_next = probe_hit ? S_DONE : S_BIN_RD;
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake and ram port
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = entry_count[AW-1:0];
    ram_wdata = WIDTH'(req.value);
    ram_re    = 1'b0;
    ram_raddr = scan_addr[AW-1:0];
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        ram_we    = req.valid && (req.command == CMD_APPEND) && !store_full;
      end
      S_LIN: begin
        ram_re = scan_re;
      end
      S_BIN_RD: begin
        ram_re    = bin_go;
        ram_raddr = mid;
      end
      S_BIN_CMP, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= scan_re;
      if (accept) begin
        case (req.command)
          CMD_CLEAR:  entry_count <= '0;
          CMD_APPEND: if (!store_full) entry_count <= entry_count + CNT_W'(1);
          default:    ;
        endcase
      end
      if (state == S_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      key        <= WIDTH'(req.value);
      res_status <= (req.command == CMD_APPEND) && store_full;
      lin_found  <= 1'b0;
      lin_idx    <= '0;
      lin_cnt    <= '0;
      bin_found  <= 1'b0;
      bin_idx    <= '0;
      bin_cnt    <= '0;
      scan_addr  <= '0;
      low        <= '0;
      hi_ex      <= entry_count;
    end
    if (scan_re) begin
      scan_addr <= scan_addr + CNT_W'(1);
      pend_idx  <= scan_addr[AW-1:0];
    end
    if (state == S_LIN && lin_stop) begin
      lin_cnt <= CNT_W'(pend_idx) + CNT_W'(1);
      if (lin_hit) begin
        lin_found <= 1'b1;
        lin_idx   <= pend_idx;
      end
    end
    if (state == S_BIN_RD && bin_go) begin
      bin_cnt   <= bin_cnt + CNT_W'(1);
      probe_idx <= mid;
    end
    if (state == S_BIN_CMP) begin
      if (probe_hit) begin
        bin_found <= 1'b1;
        bin_idx   <= probe_idx;
      end else if (ram_rdata < key) begin
        low <= CNT_W'(probe_idx) + CNT_W'(1);
      end else begin
        hi_ex <= CNT_W'(probe_idx);
      end
    end
  end

  // output register payload, fields cut to their item widths
  always_ff @(posedge clk) begin
    if (state == S_DONE && slot_free) begin
      o_status    <= res_status;
      o_lin_found <= lin_found;
      o_lin_index <= IDX_W'(lin_idx);
      o_lin_count <= LCNT_W'(lin_cnt);
      o_bin_found <= bin_found;
      o_bin_index <= IDX_W'(bin_idx);
      o_bin_count <= BCNT_W'(bin_cnt);
      o_cmp       <= cmp_code;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = o_status;
  assign rsp.linear_found   = o_lin_found;
  assign rsp.linear_index   = o_lin_index;
  assign rsp.linear_count   = o_lin_count;
  assign rsp.binary_found   = o_bin_found;
  assign rsp.binary_index   = o_bin_index;
  assign rsp.binary_count   = o_bin_count;
  assign rsp.compare_result = o_cmp;

`ifndef SYNTHESIS
  // fill level never passes the store depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // binary window never inverts while probing
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_BIN_RD || state == S_BIN_CMP) |-> low <= hi_ex)
    else $error("binary window inverted");

  // linear scan never counts more compares than filled entries
  a_lin_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> lin_cnt <= entry_count)
    else $error("linear count beyond fill level");

  // a finished item reaches the output register once the slot frees
  a_deliver: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && slot_free) |=> (out_valid && state == S_IDLE))
    else $error("result not registered");
`endif

endmodule

>>> sim/linear_binary_search_compare_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_binary_search_compare_test
// drives clear, append and query items into the search block with random
// idling on both sides, predicts each result from a mirror of the store and
// checks every result field against the prediction
// ----------------------------------------------------------------------------
module linear_binary_search_compare_test import lbsc_pkg::*; ();

  localparam int STORE_DEPTH   = DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int TAIL_ITEMS    = 80;        // no idling once this few items remain
  localparam int SETTLE_CYCLES = 100;       // settle time after the last result, longer than the longest query
  localparam int CYCLE_LIMIT   = 1_000_000;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic STATUS_FULL = 1'b1;

  // one command item, with a flag that holds it back until all results are in
  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    bit                 drain;
  } search_cmd_t;

  typedef struct packed {
    logic              status;
    logic              linear_found;
    logic [IDX_W-1:0]  linear_index;
    logic [LCNT_W-1:0] linear_count;
    logic              binary_found;
    logic [IDX_W-1:0]  binary_index;
    logic [BCNT_W-1:0] binary_count;
    logic [CMP_W-1:0]  compare_result;
  } search_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbsc_in_if  req ();
  lbsc_out_if rsp ();

  linear_binary_search_compare #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (VALUE_W)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // commands waiting to be sent, and results the block still owes us
  search_cmd_t    pending_cmds[$];
  search_result_t expected_results[$];
  search_cmd_t    cmd_in_flight;

  // mirror of the block's element store
  logic [VALUE_W-1:0] mirror_store[STORE_DEPTH];
  int                 mirror_count;

  int  mismatches    = 0;
  int  cycle_count   = 0;
  int  src_gap       = 0;
  int  sink_stall    = 0;
  int  src_idle_pct  = 20;
  int  sink_idle_pct = 20;
  bit  quiet;

  always #5 clk = ~clk;

  // near the end both sides run flat out
  assign quiet = pending_cmds.size() < TAIL_ITEMS;

  // --------------------------------------------------------------------------
  // prediction: apply one command to the mirror and return the expected result
  // --------------------------------------------------------------------------
  function automatic search_result_t apply_command(input logic [CMD_W-1:0]   cmd,
                                                   input logic [VALUE_W-1:0] value);
    search_result_t res;
    int  lin_probes;
    int  bin_probes;
    int  low;
    int  high;
    int  mid;
    int  idx;
    bit  hit;
    res        = '0;
    lin_probes = 0;
    bin_probes = 0;
    case (cmd)
      CMD_CLEAR: begin
        mirror_count = 0;
      end
      CMD_APPEND: begin
        // a full store drops the element and flags it
        if (mirror_count >= STORE_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          mirror_store[mirror_count] = value;
          mirror_count++;
        end
      end
      CMD_QUERY: begin
        // linear scan: one compare per entry up to and including the first hit
        hit = 1'b0;
        idx = 0;
        while (!hit && idx < mirror_count) begin
          lin_probes++;
          if (mirror_store[idx] == value) begin
            hit              = 1'b1;
            res.linear_found = 1'b1;
            res.linear_index = IDX_W'(idx);
          end
          idx++;
        end
        // binary search at the floor midpoint, run on the store as it is,
        // sorted or not; an empty store makes no probes at all
        hit  = 1'b0;
        low  = 0;
        high = mirror_count - 1;
        while (!hit && low <= high) begin
          mid = low + (high - low) / 2;
          bin_probes++;
          if (mirror_store[mid] == value) begin
            hit              = 1'b1;
            res.binary_found = 1'b1;
            res.binary_index = IDX_W'(mid);
          end else if (mirror_store[mid] < value) begin
            low = mid + 1;
          end else begin
            high = mid - 1;
          end
        end
        res.linear_count = LCNT_W'(lin_probes);
        res.binary_count = BCNT_W'(bin_probes);
        if (lin_probes > bin_probes) begin
          res.compare_result = CMP_LINEAR_MORE;
        end else if (lin_probes < bin_probes) begin
          res.compare_result = CMP_BINARY_MORE;
        end else begin
          res.compare_result = CMP_EQUAL;
        end
      end
      default: begin
        // unused command code: nothing changes, all-zero result
      end
    endcase
    return res;
  endfunction

  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                          input bit drain);
    search_cmd_t c;
    c.cmd   = cmd;
    c.value = value;
    c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: sends pending items, idles in short bursts, holds a drain item
  // back until every earlier result has come out
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        expected_results.push_back(apply_command(cmd_in_flight.cmd, cmd_in_flight.value));
      end
      if (!req.valid || req.ready) begin
        // switch between calm stretches and busy ones now and then
        if ($urandom_range(0, 63) == 0) begin
          src_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
        end
        if (src_gap > 0) begin
          src_gap--;
          req.valid <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          req.valid <= 1'b0;
        end else if (pending_cmds[0].drain &&
                     (expected_results.size() != 0 || (req.valid && req.ready))) begin
          req.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
          src_gap = $urandom_range(0, 3);
          req.valid <= 1'b0;
        end else begin
          cmd_in_flight = pending_cmds.pop_front();
          req.valid   <= 1'b1;
          req.command <= cmd_in_flight.cmd;
          req.value   <= cmd_in_flight.value;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: stalls the result channel in bursts and checks every result
  // against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    search_result_t exp_res;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no item pending, expected none, actual status %0d",
                   $time, rsp.status);
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("status",         8'(exp_res.status),         8'(rsp.status));
          check_field("linear_found",   8'(exp_res.linear_found),   8'(rsp.linear_found));
          check_field("linear_index",   8'(exp_res.linear_index),   8'(rsp.linear_index));
          check_field("linear_count",   8'(exp_res.linear_count),   8'(rsp.linear_count));
          check_field("binary_found",   8'(exp_res.binary_found),   8'(rsp.binary_found));
          check_field("binary_index",   8'(exp_res.binary_index),   8'(rsp.binary_index));
          check_field("binary_count",   8'(exp_res.binary_count),   8'(rsp.binary_count));
          check_field("compare_result", 8'(exp_res.compare_result),
                      8'(rsp.compare_result));
        end
      end
      if ($urandom_range(0, 63) == 0) begin
        sink_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < sink_idle_pct) begin
        sink_stall = $urandom_range(0, 3);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    logic [VALUE_W-1:0] seg_vals[$];
    int  counted;
    int  n_app;
    int  n_qry;
    int  step_max;
    int  next_val;
    int  pick;
    bit  sorted;
    bit  first_seg;
    logic [VALUE_W-1:0] key;

    req.valid   = 1'b0;
    req.command = CMD_CLEAR;
    req.value   = '0;
    rsp.ready   = 1'b0;
    mirror_count = 0;
    foreach (mirror_store[i]) mirror_store[i] = '0;

    // directed: empty store, field extremes, unused code, unsorted store
    push_cmd(CMD_QUERY,  16'h0000, 1'b0);   // empty store, no compares
    push_cmd(CMD_APPEND, 16'h0000, 1'b0);
    push_cmd(CMD_APPEND, 16'h7FFF, 1'b0);
    push_cmd(CMD_APPEND, 16'hFFFF, 1'b0);
    push_cmd(CMD_QUERY,  16'h0000, 1'b0);
    push_cmd(CMD_QUERY,  16'hFFFF, 1'b0);
    push_cmd(CMD_QUERY,  16'h7FFF, 1'b0);
    push_cmd(CMD_QUERY,  16'h8000, 1'b0);   // miss between entries
    push_cmd(CMD_UNUSED, 16'hFFFF, 1'b0);
    push_cmd(CMD_QUERY,  16'hFFFF, 1'b1);   // wait for everything before this one
    push_cmd(CMD_CLEAR,  16'hFFFF, 1'b0);
    push_cmd(CMD_APPEND, 16'd500,  1'b0);
    push_cmd(CMD_APPEND, 16'd100,  1'b0);
    push_cmd(CMD_QUERY,  16'd100,  1'b0);   // unsorted: binary search misses
    push_cmd(CMD_QUERY,  16'd500,  1'b0);
    push_cmd(CMD_CLEAR,  16'h5555, 1'b0);
    push_cmd(CMD_QUERY,  16'h5555, 1'b0);   // empty again after clear
    push_cmd(CMD_APPEND, 16'hAAAA, 1'b0);
    push_cmd(CMD_QUERY,  16'hAAAA, 1'b0);
    push_cmd(CMD_QUERY,  16'h5555, 1'b0);

    // random: mostly clear, a run of appends (usually ascending), then queries;
    // some segments overfill the store, some skip the clear, a few noise items
    counted   = 0;
    first_seg = 1'b1;
    while (counted < RANDOM_ITEMS) begin
      if (first_seg || $urandom_range(0, 7) != 0) begin
        push_cmd(CMD_CLEAR, 16'($urandom()), 1'b0);
        counted++;
      end
      if (first_seg || $urandom_range(0, 9) == 0) begin
        n_app = $urandom_range(60, 70);     // may reach and pass a full store
      end else begin
        n_app = $urandom_range(0, 16);
      end
      sorted   = first_seg || $urandom_range(0, 9) < 7;
      step_max = ($urandom_range(0, 1) == 0) ? 3 : 2000;
      next_val = $urandom_range(0, 1023);
      seg_vals.delete();
      for (int k = 0; k < n_app; k++) begin
        if (sorted) begin
          seg_vals.push_back(VALUE_W'(next_val));
          next_val = next_val + $urandom_range(0, step_max);
          if (next_val > 16'hFFFF) next_val = 16'hFFFF;
        end else begin
          seg_vals.push_back(16'($urandom()));
        end
        push_cmd(CMD_APPEND, seg_vals[k], 1'b0);
        counted++;
      end
      n_qry = $urandom_range(1, 8);
      for (int k = 0; k < n_qry; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6 && seg_vals.size() > 0) begin
          key = seg_vals[$urandom_range(0, seg_vals.size() - 1)];
          if (pick == 5) key = key + 1'b1;  // near miss: one above an appended value
        end else if (pick < 8) begin
          key = 16'($urandom());
        end else if (pick == 8) begin
          key = 16'h0000;
        end else begin
          key = 16'hFFFF;
        end
        push_cmd(CMD_QUERY, key, k == 0 && $urandom_range(0, 11) == 0);
        counted++;
        if ($urandom_range(0, 19) == 0) push_cmd(CMD_UNUSED, 16'($urandom()), 1'b0);
      end
      first_seg = 1'b0;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || req.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/lbsc_pkg.sv
hw/rtl/lbsc_in_if.sv
hw/rtl/lbsc_out_if.sv
hw/rtl/lbsc_ram.sv
hw/rtl/linear_binary_search_compare.sv
sim/linear_binary_search_compare_test.sv
